/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// short forms for clocked concurrent assertions with synchronous reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/ccsi_pkg.sv */
// ----------------------------------------------------------------------------
// ccsi_pkg
// constants and codes shared by the command checksum inserter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ccsi_pkg;

  // longest extended frame accepted without an overlong error
  localparam int MAX_FRAME_BYTES = 256;
  // byte position counter, able to hold MAX_FRAME_BYTES itself
  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

  localparam logic [7:0] EXT_MASK = 8'h78;
  localparam int HDR_W = 11;
  localparam int BODY_START = 6;
  localparam int EXT_HDR_LAST = 3;

  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_SHORT    = 2'd1,
    ERR_OVERLONG = 2'd2
  } err_code_t;

endpackage

/* rtl/command_checksum_inserter_core.sv */
// ----------------------------------------------------------------------------
// command_checksum_inserter_core
// computes the 8-bit folded checksum and 16-bit body checksum of a command
// frame as its bytes stream in, one result per frame at the last byte
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata (low bit up)                      | side bands
//  ---------+-----+-----------------------------------------+-------------------
//  in_      | in  | frame_byte[7:0]                         | tlast = frame_end
//  out_     | out | sum8[7:0] sum16[23:8] fault_code[25:24] | tuser = is_extended
//
//  one byte is taken per cycle; the running sums sit in the frame state
//  registers and the result of the last byte goes straight to the output
//  register, so a frame gives its result in the cycle after its last byte.
//  in_tready drops only while a result waits in the output register and
//  out_tready is low; a waiting result and the next byte move in the same cycle
//  synchronous active-low reset clears the frame state and the output valid
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module command_checksum_inserter_core (
  input  logic                             clk,
  input  logic                             rst_n,
  // input byte stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ccsi_pkg::IN_DATA_W-1:0]   in_tdata,   // frame_byte[7:0]
  input  logic                             in_tlast,   // frame_end
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ccsi_pkg::OUT_DATA_W-1:0]  out_tdata,  // sum8, sum16, fault_code
  output logic                             out_tuser   // is_extended
);

  localparam int PW = ccsi_pkg::POS_W;
  localparam int HW = ccsi_pkg::HDR_W;

  // frame state
  logic [PW-1:0]  pos_r, pos_nxt;
  logic [7:0]     form_r, form_nxt;
  logic [HW-1:0]  hdr_r, hdr_nxt;
  logic [15:0]    body_r, body_nxt;
  logic           ovl_r, ovl_nxt;

  // output register
  logic                            out_valid_r, out_valid_nxt;
  logic [ccsi_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                            out_user_r, out_user_nxt;

  // per-byte working values
  logic                  in_xfer;
  logic [7:0]            in_byte;
  logic [7:0]            form_cur;
  logic                  ext;
  logic [3:0]            decl_len;
  logic                  hdr_take;
  logic                  body_take;
  logic                  at_limit;
  logic [HW-1:0]         hdr_cur;
  logic [15:0]           body_cur;
  logic                  ovl_cur;
  logic                  too_short;
  ccsi_pkg::err_code_t   err;
  logic [11:0]           total;
  logic [7:0]            sum8;
  logic [15:0]           sum16;

  // end-around-carry fold to 8 bits, applied twice
  function automatic logic [7:0] fold8(input logic [11:0] s);
    logic [8:0] x1;
    logic [8:0] x2;
    x1 = 9'(s[7:0]) + 9'(s[11:8]);
    x2 = 9'(x1[7:0]) + 9'(x1[8]);
    return x2[7:0];
  endfunction

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign in_byte   = in_tdata[7:0];

  always_comb begin
    // byte 1 picks the form, and already counts for this byte
    form_cur = (pos_r == PW'(1)) ? in_byte : form_r;
    ext      = (form_cur & ccsi_pkg::EXT_MASK) == ccsi_pkg::EXT_MASK;
    decl_len = 4'd2 + {1'b0, form_cur[2:0]};

    // header covers bytes 1..3 (extended) or 1..len-1 (normal)
    hdr_take  = (pos_r != '0) &&
                (ext ? (pos_r <= PW'(ccsi_pkg::EXT_HDR_LAST)) : (pos_r < PW'(decl_len)));
    body_take = ext && (pos_r >= PW'(ccsi_pkg::BODY_START));

    hdr_cur  = hdr_take ? (hdr_r + HW'(in_byte)) : hdr_r;
    body_cur = body_take ? (body_r + 16'(in_byte)) : body_r;

    // position saturates; a byte past the limit marks the frame overlong
    at_limit = pos_r >= PW'(ccsi_pkg::MAX_FRAME_BYTES);
    ovl_cur  = ovl_r || at_limit;

    // count = pos + 1 is below decl_len
    too_short = pos_r < PW'(decl_len - 4'd1);

    if (ext) begin
      err = ovl_cur ? ccsi_pkg::ERR_OVERLONG : ccsi_pkg::ERR_OK;
    end else begin
      err = too_short ? ccsi_pkg::ERR_SHORT : ccsi_pkg::ERR_OK;
    end

    // extended checksum also folds in both bytes of the body sum
    if (ext) begin
      total = 12'(hdr_cur) + 12'(body_cur[7:0]) + 12'(body_cur[15:8]);
    end else begin
      total = 12'(hdr_cur);
    end

    if (err == ccsi_pkg::ERR_OK) begin
      sum8  = fold8(total);
      sum16 = ext ? body_cur : 16'd0;
    end else begin
      sum8  = 8'd0;
      sum16 = 16'd0;
    end
  end

  // next frame state
  always_comb begin
    pos_nxt  = pos_r;
    form_nxt = form_r;
    hdr_nxt  = hdr_r;
    body_nxt = body_r;
    ovl_nxt  = ovl_r;
    if (in_xfer) begin
      if (in_tlast) begin
        // frame done: start over
        pos_nxt  = '0;
        form_nxt = '0;
        hdr_nxt  = '0;
        body_nxt = '0;
        ovl_nxt  = 1'b0;
      end else begin
        pos_nxt  = at_limit ? pos_r : (pos_r + PW'(1));
        form_nxt = form_cur;
        hdr_nxt  = hdr_cur;
        body_nxt = body_cur;
        ovl_nxt  = ovl_cur;
      end
    end
  end

  // next output register contents
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_xfer && in_tlast) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {6'd0, err, sum16, sum8};
      out_user_nxt  = ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      form_r      <= '0;
      hdr_r       <= '0;
      body_r      <= '0;
      ovl_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      form_r      <= form_nxt;
      hdr_r       <= hdr_nxt;
      body_r      <= body_nxt;
      ovl_r       <= ovl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // a frame end always restarts the byte count
  `ASSERT_NEXT(a_pos_restart, in_xfer && in_tlast, pos_r == '0)

  // an errored result carries zero checksums
  `ASSERT_ALWAYS(a_err_zero_sums, !out_valid_r ||
      out_data_r[25:24] == ccsi_pkg::ERR_OK ||
      (out_data_r[23:0] == 24'd0))

  // the short error only for normal frames, overlong only for extended
  `ASSERT_ALWAYS(a_err_matches_form, !out_valid_r ||
      (out_data_r[25:24] == ccsi_pkg::ERR_OK) ||
      (out_data_r[25:24] == ccsi_pkg::ERR_SHORT && !out_user_r) ||
      (out_data_r[25:24] == ccsi_pkg::ERR_OVERLONG && out_user_r))

  // normal frames never report a body sum
  `ASSERT_ALWAYS(a_normal_no_sum16, !out_valid_r || out_user_r ||
      out_data_r[23:8] == 16'd0)

endmodule

/* test/command_checksum_inserter_core_tb.sv */
// ----------------------------------------------------------------------------
// command_checksum_inserter_core_tb
// streams command frames of normal and extended form through the checksum
// inserter with random gaps and output stalls, predicts the per-frame sums,
// form and fault code, and compares every result transfer field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module command_checksum_inserter_core_tb;

  localparam int BYTE_TARGET = 1600;
  localparam int QUIET_FROM = 1400;
  localparam int PW = ccsi_pkg::POS_W;

  typedef enum int {FILL_RAND, FILL_ZERO, FILL_ONES} fill_t;

  typedef struct {
    logic [7:0]          sum8;
    logic [15:0]         sum16;
    logic                ext;
    ccsi_pkg::err_code_t err;
  } frame_result_t;

  // running frame sums and the queue of results they predict
  class checksum_scoreboard;
    frame_result_t   pending_results[$];
    logic [PW-1:0]                  pos;
    logic [7:0]                     form;
    logic [ccsi_pkg::HDR_W-1:0]     hdr_sum;
    logic [15:0]                    body_sum;
    logic                           overlong;
    int errors;
    int frames;
    int ext_frames;
    int short_frames;
    int overlong_frames;

    function new();
      clear_frame();
      errors = 0;
      frames = 0;
      ext_frames = 0;
      short_frames = 0;
      overlong_frames = 0;
    endfunction

    function void clear_frame();
      pos = '0;
      form = '0;
      hdr_sum = '0;
      body_sum = '0;
      overlong = 1'b0;
    endfunction

    // end-around carry, applied twice
    function logic [7:0] fold_carry(int unsigned s);
      int unsigned x;
      x = (s & 32'hFF) + (s >> 8);
      x = (x & 32'hFF) + (x >> 8);
      return x[7:0];
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      int unsigned p;
      int unsigned decl_len;
      logic ext;
      frame_result_t r;
      p = pos;
      if (p == 1) form = b;
      ext = (form & ccsi_pkg::EXT_MASK) == ccsi_pkg::EXT_MASK;
      decl_len = 2 + form[2:0];
      if (p >= 1) begin
        if (ext ? (p <= ccsi_pkg::EXT_HDR_LAST) : (p < decl_len)) hdr_sum = hdr_sum + b;
        if (ext && p >= ccsi_pkg::BODY_START) body_sum = body_sum + b;
      end
      if (p >= ccsi_pkg::MAX_FRAME_BYTES) overlong = 1'b1;
      else pos = PW'(p + 1);
      if (!last) return;
      r.ext = ext;
      r.sum8 = '0;
      r.sum16 = '0;
      if (ext) r.err = overlong ? ccsi_pkg::ERR_OVERLONG : ccsi_pkg::ERR_OK;
      else r.err = (p + 1 < decl_len) ? ccsi_pkg::ERR_SHORT : ccsi_pkg::ERR_OK;
      if (r.err == ccsi_pkg::ERR_OK) begin
        if (ext) begin
          r.sum16 = body_sum;
          r.sum8 = fold_carry(hdr_sum + body_sum[7:0] + body_sum[15:8]);
        end else begin
          r.sum8 = fold_carry(hdr_sum);
        end
      end
      frames++;
      if (ext) ext_frames++;
      if (r.err == ccsi_pkg::ERR_SHORT) short_frames++;
      if (r.err == ccsi_pkg::ERR_OVERLONG) overlong_frames++;
      pending_results.push_back(r);
      clear_frame();
    endfunction

    function void check_result(logic [ccsi_pkg::OUT_DATA_W-1:0] data, logic user);
      frame_result_t r;
      if (pending_results.size() == 0) begin
        $error("result transfer with no frame pending: tdata %0h tuser %0b", data, user);
        errors++;
        return;
      end
      r = pending_results.pop_front();
      if (data[7:0] !== r.sum8) begin
        $error("sum8 expected %0h actual %0h", r.sum8, data[7:0]);
        errors++;
      end
      if (data[23:8] !== r.sum16) begin
        $error("sum16 expected %0h actual %0h", r.sum16, data[23:8]);
        errors++;
      end
      if (data[25:24] !== r.err) begin
        $error("fault_code expected %0d actual %0d", r.err, data[25:24]);
        errors++;
      end
      if (user !== r.ext) begin
        $error("is_extended expected %0b actual %0b", r.ext, user);
        errors++;
      end
      if (data[ccsi_pkg::OUT_DATA_W-1:26] !== '0) begin
        $error("tdata padding expected 0 actual %0h", data[ccsi_pkg::OUT_DATA_W-1:26]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [ccsi_pkg::IN_DATA_W-1:0] in_tdata = '0;   // frame_byte[7:0]
  logic in_tlast = 1'b0;                           // frame_end
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [ccsi_pkg::OUT_DATA_W-1:0] out_tdata;  // sum8[7:0], sum16[23:8], fault_code[25:24]
  logic out_tuser;                             // is_extended

  checksum_scoreboard sb = new();
  logic idling = 1'b1;
  int bytes_sent = 0;
  int stall_left = 0;

  command_checksum_inserter_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  // result side: check each transfer, stall in random bursts while idling is on
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    if (stall_left > 0) stall_left--;
    else if (idling && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 19);
    out_tready <= (stall_left == 0);
  end

  // one byte transfer, with an optional gap before it
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idling && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b, last);
    bytes_sent++;
  endtask

  // whole frame; byte 1 carries the form, the rest follows the fill
  task automatic send_frame(input int len, input logic [7:0] form, input fill_t fill);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default:   b = 8'($urandom_range(0, 255));
      endcase
      if (i == 1) b = form;
      send_byte(b, i == len - 1);
    end
  endtask

  function automatic logic [7:0] normal_form();
    logic [7:0] f;
    do f = 8'($urandom_range(0, 255)); while ((f & ccsi_pkg::EXT_MASK) == ccsi_pkg::EXT_MASK);
    return f;
  endfunction

  initial begin
    logic [7:0] form;
    int kind;
    int len;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames
    send_frame(1, 8'h00, FILL_ONES);      // ends before the form byte
    send_frame(2, 8'h00, FILL_ZERO);      // shortest normal frame
    send_frame(2, 8'h70, FILL_ONES);      // near the extended mask, still normal
    send_frame(9, 8'h07, FILL_ONES);      // longest normal frame, all ones
    send_frame(5, 8'h87, FILL_RAND);      // normal, shorter than declared
    send_frame(12, 8'h03, FILL_RAND);     // normal, extra bytes ignored
    send_frame(2, 8'h78, FILL_RAND);      // extended, header cut short
    send_frame(3, 8'hF8, FILL_ONES);      // extended, no body
    send_frame(6, 8'hFF, FILL_ONES);      // extended, ends just before the body
    send_frame(40, 8'h7F, FILL_ONES);     // extended, long body
    send_frame(ccsi_pkg::MAX_FRAME_BYTES, 8'hF8, FILL_ONES);      // longest legal extended
    send_frame(ccsi_pkg::MAX_FRAME_BYTES + 1, 8'h78, FILL_RAND);  // first overlong length
    send_frame(ccsi_pkg::MAX_FRAME_BYTES + 44, 8'hFB, FILL_ZERO); // overlong, counter held

    // random frames, mostly well formed; idling off in some stretches and at the end
    while (bytes_sent < BYTE_TARGET) begin
      idling <= (bytes_sent < QUIET_FROM) && ((bytes_sent / 250) % 3 != 2);
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        form = normal_form();
        len = 2 + form[2:0];
      end else if (kind < 80) begin
        form = 8'($urandom_range(0, 255)) | ccsi_pkg::EXT_MASK;
        if ($urandom_range(0, 24) == 0) len = $urandom_range(ccsi_pkg::MAX_FRAME_BYTES - 6,
                                                             ccsi_pkg::MAX_FRAME_BYTES + 6);
        else len = $urandom_range(1, 48);
      end else if (kind < 90) begin
        form = normal_form();
        len = $urandom_range(1, 1 + form[2:0]);
      end else begin
        form = normal_form();
        len = 2 + form[2:0] + $urandom_range(1, 6);
      end
      send_frame(len, form, FILL_RAND);
    end
    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.pending_results.size() != 0) sb.errors++;

    $display("checked %0d frames from %0d byte transfers: %0d extended, %0d short, %0d overlong",
             sb.frames, bytes_sent, sb.ext_frames, sb.short_frames, sb.overlong_frames);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hang guard
  initial begin
    #10ms;
    $display("timeout: frames still pending");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/ccsi_pkg.sv
rtl/command_checksum_inserter_core.sv
test/command_checksum_inserter_core_tb.sv
